[rtl/sldf_pkg.sv]
`default_nettype none

package sldf_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CheckW  = 16;
  localparam int unsigned StatusW = 3;
  localparam int unsigned PhaseW  = 3;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CheckW-1:0] CheckReset = 16'd39304;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgSyncFirst     = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSyncSecond    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgExpectedCheck = 2'd2;

  // result status codes
  localparam logic [StatusW-1:0] StSync    = 3'd0;
  localparam logic [StatusW-1:0] StHeader  = 3'd1;
  localparam logic [StatusW-1:0] StPayload = 3'd2;
  localparam logic [StatusW-1:0] StChkHi   = 3'd3;
  localparam logic [StatusW-1:0] StAccept  = 3'd4;
  localparam logic [StatusW-1:0] StFail    = 3'd5;

  typedef struct packed {
    logic [ByteW-1:0]  sync_first;
    logic [ByteW-1:0]  sync_second;
    logic [CheckW-1:0] expected_check;
  } cfg_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [ByteW-1:0]   data_byte;
    logic [ByteW-1:0]   payload_index;
    logic               last_payload;
    logic [ByteW-1:0]   frame_type;
    logic [ByteW-1:0]   frame_length;
    logic [CheckW-1:0]  received_check;
  } result_t;

endpackage

`default_nettype wire

[rtl/sldf_cfg.sv]
`default_nettype none

module sldf_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [sldf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [sldf_pkg::CheckW-1:0]    cfg_wdata_i,
  output sldf_pkg::cfg_t                      cfg_o
);
  import sldf_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSyncFirst:     cfg_d.sync_first     = cfg_wdata_i[ByteW-1:0];
        CfgSyncSecond:    cfg_d.sync_second    = cfg_wdata_i[ByteW-1:0];
        CfgExpectedCheck: cfg_d.expected_check = cfg_wdata_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first     <= '0;
      cfg_q.sync_second    <= '0;
      cfg_q.expected_check <= CheckReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/sldf_fsm.sv]
`default_nettype none

module sldf_fsm (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        step_i,
  input  wire logic [sldf_pkg::ByteW-1:0]  byte_i,
  input  wire sldf_pkg::cfg_t              cfg_i,
  output sldf_pkg::result_t                res_o
);
  import sldf_pkg::*;

  localparam logic [PhaseW-1:0] PhSync1  = 3'd0;
  localparam logic [PhaseW-1:0] PhSync2  = 3'd1;
  localparam logic [PhaseW-1:0] PhType   = 3'd2;
  localparam logic [PhaseW-1:0] PhLength = 3'd3;
  localparam logic [PhaseW-1:0] PhData   = 3'd4;
  localparam logic [PhaseW-1:0] PhChkHi  = 3'd5;
  localparam logic [PhaseW-1:0] PhChkLo  = 3'd6;

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [ByteW-1:0]  type_q, type_d;
  logic [ByteW-1:0]  length_q, length_d;
  logic [ByteW-1:0]  count_q, count_d;
  logic [ByteW-1:0]  chk_hi_q, chk_hi_d;
  logic [ByteW:0]    count_next;
  logic [CheckW-1:0] check_word;

  assign count_next = {1'b0, count_q} + {{ByteW{1'b0}}, 1'b1};
  assign check_word = {chk_hi_q, byte_i};

  always_comb begin
    phase_d  = phase_q;
    type_d   = type_q;
    length_d = length_q;
    count_d  = count_q;
    chk_hi_d = chk_hi_q;
    res_o    = '0;
    res_o.status = StSync;
    unique case (phase_q)
      PhSync2: begin
        if (byte_i == cfg_i.sync_second) begin
          phase_d = PhType;
        end else begin
          phase_d = PhSync1;
          count_d = '0;
        end
      end
      PhType: begin
        type_d       = byte_i;
        phase_d      = PhLength;
        res_o.status = StHeader;
      end
      PhLength: begin
        length_d     = byte_i;
        phase_d      = (byte_i == '0) ? PhChkHi : PhData;
        res_o.status = StHeader;
      end
      PhData: begin
        res_o.status        = StPayload;
        res_o.data_byte     = byte_i;
        res_o.payload_index = count_q;
        if (count_next >= {1'b0, length_q}) begin
          res_o.last_payload = 1'b1;
          phase_d            = PhChkHi;
        end
        count_d = count_next[ByteW-1:0];
      end
      PhChkHi: begin
        chk_hi_d     = byte_i;
        phase_d      = PhChkLo;
        res_o.status = StChkHi;
      end
      PhChkLo: begin
        res_o.received_check = check_word;
        res_o.status = (check_word == cfg_i.expected_check) ? StAccept : StFail;
        phase_d      = PhSync1;
        count_d      = '0;
      end
      default: begin
        phase_d = (byte_i == cfg_i.sync_first) ? PhSync2 : PhSync1;
      end
    endcase
    res_o.frame_type   = type_d;
    res_o.frame_length = length_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhSync1;
      type_q   <= '0;
      length_q <= '0;
      count_q  <= '0;
      chk_hi_q <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      type_q   <= type_d;
      length_q <= length_d;
      count_q  <= count_d;
      chk_hi_q <= chk_hi_d;
    end
  end

endmodule

`default_nettype wire

[rtl/sync_length_check_deframer.sv]
// Sync / length / check-word deframer for a received byte stream.
//
// Input channel rx: one received byte per transaction (rx_valid_i, rx_ready_o,
// rx_byte_i). Result channel res: one result per input byte (res_valid_o,
// res_ready_i) carrying status, payload byte and index, last flag, header
// fields and the assembled check word on the frame-end result.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0 first sync byte, 1 second sync byte, 2 expected check word); write only
// while no byte is in flight.
//
// Path: a byte accepted from rx sits in the input register and moves into the
// result register when that is free, and its result is then offered on res.
// Throughput: one byte per clock while res_ready_i does not stall the output;
// the frame state advances once per byte.
// Stall: while res_ready_i is low the result holds, the input register still
// takes one byte, and rx_ready_o then drops until the result is taken.
// Reset: both registers empty, hunting for the first sync byte, held header
// fields and counters cleared, sync bytes 0 and expected check word 0x9988.
`default_nettype none

module sync_length_check_deframer (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [sldf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [sldf_pkg::CheckW-1:0]    cfg_wdata_i,
  input  wire logic                           rx_valid_i,
  output logic                                rx_ready_o,
  input  wire logic [sldf_pkg::ByteW-1:0]     rx_byte_i,
  output logic                                res_valid_o,
  input  wire logic                           res_ready_i,
  output logic [sldf_pkg::StatusW-1:0]        status_o,
  output logic [sldf_pkg::ByteW-1:0]          data_byte_o,
  output logic [sldf_pkg::ByteW-1:0]          payload_index_o,
  output logic                                last_payload_o,
  output logic [sldf_pkg::ByteW-1:0]          frame_type_o,
  output logic [sldf_pkg::ByteW-1:0]          frame_length_o,
  output logic [sldf_pkg::CheckW-1:0]         received_check_o
);
  import sldf_pkg::*;

  cfg_t       cfg;
  result_t    res_d, res_q;
  logic       in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic       out_valid_q;
  logic       advance;

  // advance the held byte into the result register when it is free
  assign advance    = in_valid_q && (!out_valid_q || res_ready_i);
  assign rx_ready_o = !in_valid_q || advance;

  sldf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  sldf_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rx_ready_o) begin
        in_valid_q <= rx_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_valid_i && rx_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o      = out_valid_q;
  assign status_o         = res_q.status;
  assign data_byte_o      = res_q.data_byte;
  assign payload_index_o  = res_q.payload_index;
  assign last_payload_o   = res_q.last_payload;
  assign frame_type_o     = res_q.frame_type;
  assign frame_length_o   = res_q.frame_length;
  assign received_check_o = res_q.received_check;

endmodule

`default_nettype wire
